### sv/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

   // Cache geometry.
   localparam int OFFSET_BITS = 4;
   localparam int INDEX_BITS  = 3;
   localparam int TAG_BITS    = 5;
   localparam int ADDR_BITS   = OFFSET_BITS + INDEX_BITS + TAG_BITS;
   localparam int LINE_BYTES  = 1 << OFFSET_BITS;
   localparam int NUM_LINES   = 1 << INDEX_BITS;
   localparam int RAM_BYTES   = 1 << ADDR_BITS;
   localparam int CACHE_BYTES = NUM_LINES * LINE_BYTES;

   // Field widths.
   localparam int DATA_BITS      = 8;
   localparam int CNT_BITS       = 24;
   localparam int COST_BITS      = 8;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CNT_BITS-1:0]  CNT_MAX         = '1;
   localparam logic [COST_BITS-1:0] HIT_COST_RESET  = COST_BITS'(1);
   localparam logic [COST_BITS-1:0] MISS_COST_RESET = COST_BITS'(10);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIT_COST  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_MISS_COST = CSR_INDEX_BITS'(1);

   // Request operation codes.
   localparam logic OP_PRELOAD = 1'b0;
   localparam logic OP_READ    = 1'b1;

   typedef struct packed {
      logic capture;
      logic preload;
      logic lookup;
      logic fill_start;
      logic fill_step;
      logic tag_write;
      logic line_read;
      logic result_load;
   } dmc_cmd_type;

   typedef struct packed {
      logic hit;
      logic fill_last;
      logic rsp_free;
   } dmc_status_type;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_LOOKUP   = 6'b000010,
      ST_FILL     = 6'b000100,
      ST_FILL_END = 6'b001000,
      ST_READ     = 6'b010000,
      ST_RESULT   = 6'b100000
   } dmc_state_type;

   // Saturating add of a cost or increment to a running total.
   function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] total,
                                                   input logic [COST_BITS-1:0] inc);
      logic [CNT_BITS:0] sum;
      sum = {1'b0, total} + {{(CNT_BITS + 1 - COST_BITS){1'b0}}, inc};
      return sum[CNT_BITS] ? CNT_MAX : sum[CNT_BITS-1:0];
   endfunction

endpackage

### sv/dmc_ifs.sv
`timescale 1ns / 1ps

interface dmc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               op;
   logic [dmc_pkg::ADDR_BITS-1:0]      address;
   logic [dmc_pkg::DATA_BITS-1:0]      load_data;

   modport source (output valid, output op, output address, output load_data, input ready);
   modport sink   (input valid, input op, input address, input load_data, output ready);
endinterface

interface dmc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dmc_pkg::DATA_BITS-1:0]      read_data;
   logic                               hit;
   logic [dmc_pkg::CNT_BITS-1:0]       access_count;
   logic [dmc_pkg::CNT_BITS-1:0]       miss_count;
   logic [dmc_pkg::CNT_BITS-1:0]       time_total;

   modport source (output valid, output read_data, output hit, output access_count,
                   output miss_count, output time_total, input ready);
   modport sink   (input valid, input read_data, input hit, input access_count,
                   input miss_count, input time_total, output ready);
endinterface

interface dmc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dmc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [dmc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/dmc_ram.sv
`timescale 1ns / 1ps

module dmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dmc_controller.sv
`timescale 1ns / 1ps

module dmc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   input  dmc_pkg::dmc_status_type status,
   output dmc_pkg::dmc_cmd_type    cmd
);

   dmc_pkg::dmc_state_type state_ff;
   dmc_pkg::dmc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         dmc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == dmc_pkg::OP_READ) begin
                  cmd.capture = 1'b1;
                  state_in    = dmc_pkg::ST_LOOKUP;
               end else begin
                  // A preload writes the backing RAM in the transfer cycle itself.
                  cmd.preload = 1'b1;
               end
            end
         end
         dmc_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (status.hit) begin
               cmd.line_read = 1'b1;
               state_in      = dmc_pkg::ST_RESULT;
            end else begin
               cmd.fill_start = 1'b1;
               state_in       = dmc_pkg::ST_FILL;
            end
         end
         dmc_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = dmc_pkg::ST_FILL_END;
            end
         end
         dmc_pkg::ST_FILL_END: begin
            // The last fetched byte lands in the line here.
            cmd.tag_write = 1'b1;
            state_in      = dmc_pkg::ST_READ;
         end
         dmc_pkg::ST_READ: begin
            cmd.line_read = 1'b1;
            state_in      = dmc_pkg::ST_RESULT;
         end
         dmc_pkg::ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.result_load = 1'b1;
               state_in        = dmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/dmc_datapath.sv
`timescale 1ns / 1ps

module dmc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dmc_pkg::dmc_cmd_type              cmd,
   output dmc_pkg::dmc_status_type           status,
   input  logic [dmc_pkg::ADDR_BITS-1:0]     req_address,
   input  logic [dmc_pkg::DATA_BITS-1:0]     req_load_data,
   dmc_csr_if.sink                           csr_port,
   dmc_rsp_if.source                         rsp_port
);

   localparam int LINE_ADDR_BITS = dmc_pkg::INDEX_BITS + dmc_pkg::OFFSET_BITS;
   localparam int BLOCK_BITS     = dmc_pkg::ADDR_BITS - dmc_pkg::OFFSET_BITS;

   logic [dmc_pkg::ADDR_BITS-1:0]   addr_ff;
   logic [dmc_pkg::TAG_BITS-1:0]    tag_ff [dmc_pkg::NUM_LINES];
   logic [dmc_pkg::NUM_LINES-1:0]   line_valid_ff;
   logic                            hit_ff;
   logic [dmc_pkg::OFFSET_BITS-1:0] fill_cnt_ff;
   logic [dmc_pkg::OFFSET_BITS-1:0] fill_cnt_in;
   logic                            fill_pend_ff;
   logic [dmc_pkg::OFFSET_BITS-1:0] fill_idx_ff;
   logic [dmc_pkg::COST_BITS-1:0]   hit_cost_ff;
   logic [dmc_pkg::COST_BITS-1:0]   miss_cost_ff;
   logic [dmc_pkg::CNT_BITS-1:0]    access_ff;
   logic [dmc_pkg::CNT_BITS-1:0]    miss_ff;
   logic [dmc_pkg::CNT_BITS-1:0]    time_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [dmc_pkg::DATA_BITS-1:0]   rsp_data_ff;
   logic                            rsp_hit_ff;

   logic [dmc_pkg::INDEX_BITS-1:0]  line;
   logic [dmc_pkg::TAG_BITS-1:0]    tag;
   logic [BLOCK_BITS-1:0]           block;
   logic [dmc_pkg::COST_BITS-1:0]   cost;
   logic [dmc_pkg::DATA_BITS-1:0]   ram_rd_data;
   logic [dmc_pkg::DATA_BITS-1:0]   line_rd_data;

   assign line  = addr_ff[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];
   assign tag   = addr_ff[LINE_ADDR_BITS +: dmc_pkg::TAG_BITS];
   assign block = addr_ff[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS];
   assign cost  = hit_ff ? hit_cost_ff : miss_cost_ff;

   assign status.hit       = line_valid_ff[line] && (tag_ff[line] == tag);
   assign status.fill_last = (fill_cnt_ff == '1);
   assign status.rsp_free  = !rsp_valid_ff || rsp_port.ready;

   assign fill_cnt_in  = cmd.fill_start ? '0 : (fill_cnt_ff + dmc_pkg::OFFSET_BITS'(1));
   assign rsp_valid_in = cmd.result_load ? 1'b1 : (rsp_valid_ff && !rsp_port.ready);

   dmc_ram #(
      .WIDTH (dmc_pkg::DATA_BITS),
      .DEPTH (dmc_pkg::RAM_BYTES)
   ) u_backing_ram (
      .clock   (clock),
      .wr_en   (cmd.preload),
      .wr_addr (req_address),
      .wr_data (req_load_data),
      .rd_en   (cmd.fill_step),
      .rd_addr ({block, fill_cnt_ff}),
      .rd_data (ram_rd_data)
   );

   // Fetched bytes are written to the line RAM in the cycle after their backing RAM read.
   dmc_ram #(
      .WIDTH (dmc_pkg::DATA_BITS),
      .DEPTH (dmc_pkg::CACHE_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (fill_pend_ff),
      .wr_addr ({line, fill_idx_ff}),
      .wr_data (ram_rd_data),
      .rd_en   (cmd.line_read),
      .rd_addr (addr_ff[LINE_ADDR_BITS-1:0]),
      .rd_data (line_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= req_address;
      end
      if (cmd.lookup) begin
         hit_ff <= status.hit;
      end
      if (cmd.fill_start || cmd.fill_step) begin
         fill_cnt_ff <= fill_cnt_in;
      end
      fill_idx_ff <= fill_cnt_ff;
      if (cmd.tag_write) begin
         tag_ff[line] <= tag;
      end
      if (cmd.result_load) begin
         rsp_data_ff <= line_rd_data;
         rsp_hit_ff  <= hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         fill_pend_ff  <= 1'b0;
         hit_cost_ff   <= dmc_pkg::HIT_COST_RESET;
         miss_cost_ff  <= dmc_pkg::MISS_COST_RESET;
         access_ff     <= '0;
         miss_ff       <= '0;
         time_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_pend_ff <= cmd.fill_step;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.tag_write) begin
            line_valid_ff[line] <= 1'b1;
         end
         if (csr_port.valid) begin
            if (csr_port.index == dmc_pkg::REG_HIT_COST) begin
               hit_cost_ff <= csr_port.data;
            end
            if (csr_port.index == dmc_pkg::REG_MISS_COST) begin
               miss_cost_ff <= csr_port.data;
            end
         end
         // The totals change only when a result is loaded, so they serve as its payload.
         if (cmd.result_load) begin
            access_ff <= dmc_pkg::sat_add(access_ff, dmc_pkg::COST_BITS'(1));
            time_ff   <= dmc_pkg::sat_add(time_ff, cost);
            if (!hit_ff) begin
               miss_ff <= dmc_pkg::sat_add(miss_ff, dmc_pkg::COST_BITS'(1));
            end
         end
      end
   end

   assign csr_port.ready        = 1'b1;
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.read_data    = rsp_data_ff;
   assign rsp_port.hit          = rsp_hit_ff;
   assign rsp_port.access_count = access_ff;
   assign rsp_port.miss_count   = miss_ff;
   assign rsp_port.time_total   = time_ff;

endmodule

### sv/direct_mapped_cache_read_core.sv
`timescale 1ns / 1ps

// Channel    Role    Moves
// req_port   sink    op, address, load_data: preload of one backing byte or a read access
// rsp_port   source  read_data, hit, access_count, miss_count, time_total per read access
// csr_port   sink    index, data: write of hit_cost (0) or miss_cost (1), always ready
//
// A preload is written to the backing RAM in its transfer cycle.
// A read hit steps through capture, tag lookup with line RAM read, and result load.
// A read miss steps through capture, tag lookup, a line fill that copies one byte per cycle
// through the single read port of the backing RAM, tag write, line read, result load.
// Reset is synchronous and marks every line invalid at once; the RAMs are not cleared.
// The result register lets the next request transfer while a result waits; a stalled
// result holds the next read access in its last cycle until the result is taken.

module direct_mapped_cache_read_core (
   input  logic      clock,
   input  logic      reset,
   dmc_req_if.sink   req_port,
   dmc_rsp_if.source rsp_port,
   dmc_csr_if.sink   csr_port
);

   dmc_pkg::dmc_cmd_type    cmd;
   dmc_pkg::dmc_status_type status;

   dmc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_op    (req_port.op),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dmc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_address   (req_port.address),
      .req_load_data (req_port.load_data),
      .csr_port      (csr_port),
      .rsp_port      (rsp_port)
   );

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> status.rsp_free)
      else $error("result loaded while the previous result is still held");

   a_read_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready && (req_port.op == dmc_pkg::OP_READ))
      |=> !req_port.ready)
      else $error("request accepted while a read access is in progress");

   a_fill_then_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.tag_write |=> status.hit)
      else $error("refilled line does not match the access tag");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SETTLE_CYCLES = 24;
   localparam int IDLE_LIMIT    = 3000;
   localparam int PHASE_ITEMS   = 275;
   localparam logic [dmc_pkg::CSR_INDEX_BITS-1:0] REG_FIRST_UNUSED =
      dmc_pkg::CSR_INDEX_BITS'(2);

   typedef struct packed {
      logic                          op;
      logic [dmc_pkg::ADDR_BITS-1:0] address;
      logic [dmc_pkg::DATA_BITS-1:0] load_data;
   } cache_req_type;

   typedef struct packed {
      logic [dmc_pkg::DATA_BITS-1:0] read_data;
      logic                          hit;
      logic [dmc_pkg::CNT_BITS-1:0]  access_count;
      logic [dmc_pkg::CNT_BITS-1:0]  miss_count;
      logic [dmc_pkg::CNT_BITS-1:0]  time_total;
   } read_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmc_req_if req_if ();
   dmc_rsp_if rsp_if ();
   dmc_csr_if csr_if ();

   direct_mapped_cache_read_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus bookkeeping.
   cache_req_type                pending_reqs[$];
   int                           queued_total = 0;
   int                           accepted_total = 0;
   bit                           ram_loaded[dmc_pkg::RAM_BYTES];
   logic [dmc_pkg::TAG_BITS-1:0] hot_tags[dmc_pkg::NUM_LINES][2];

   // Predicted cache state, owned by the driver process.
   logic [dmc_pkg::DATA_BITS-1:0] ram_image[dmc_pkg::RAM_BYTES];
   logic [dmc_pkg::DATA_BITS-1:0] cached_bytes[dmc_pkg::CACHE_BYTES];
   logic [dmc_pkg::TAG_BITS-1:0]  cached_tag[dmc_pkg::NUM_LINES];
   bit                            line_live[dmc_pkg::NUM_LINES];
   logic [dmc_pkg::CNT_BITS-1:0]  access_tally, miss_tally, time_tally;
   logic [dmc_pkg::COST_BITS-1:0] hit_price, miss_price;
   read_result_type               expected_reads[$];

   int error_count = 0;

   function automatic logic [dmc_pkg::CNT_BITS-1:0] saturating_sum(
         input logic [dmc_pkg::CNT_BITS-1:0] total,
         input logic [dmc_pkg::CNT_BITS-1:0] inc);
      logic [dmc_pkg::CNT_BITS:0] sum;
      sum = {1'b0, total} + {1'b0, inc};
      if (sum[dmc_pkg::CNT_BITS]) begin
         return '1;
      end
      return sum[dmc_pkg::CNT_BITS-1:0];
   endfunction

   // Mostly random pauses, broken up by runs with no pause at all.
   task automatic draw_pause(inout int calm, output int pause);
      if (calm > 0) begin
         calm--;
         pause = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         pause = 0;
      end else begin
         pause = $urandom_range(0, 11);
      end
   endtask

   task automatic predict_access(input cache_req_type item);
      logic [dmc_pkg::OFFSET_BITS-1:0] offset;
      logic [dmc_pkg::INDEX_BITS-1:0]  set_idx;
      logic [dmc_pkg::TAG_BITS-1:0]    addr_tag;
      bit                              is_hit;
      int                              i;
      read_result_type                 res;
      if (item.op == dmc_pkg::OP_PRELOAD) begin
         ram_image[item.address] = item.load_data;
      end else begin
         offset   = item.address[dmc_pkg::OFFSET_BITS-1:0];
         set_idx  = item.address[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];
         addr_tag = item.address[dmc_pkg::OFFSET_BITS + dmc_pkg::INDEX_BITS +:
                                 dmc_pkg::TAG_BITS];
         is_hit   = line_live[set_idx] && cached_tag[set_idx] == addr_tag;
         if (!is_hit) begin
            for (i = 0; i < dmc_pkg::LINE_BYTES; i++) begin
               cached_bytes[set_idx * dmc_pkg::LINE_BYTES + i] =
                  ram_image[{item.address[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS],
                             dmc_pkg::OFFSET_BITS'(i)}];
            end
            cached_tag[set_idx] = addr_tag;
            line_live[set_idx]  = 1'b1;
            miss_tally = saturating_sum(miss_tally, dmc_pkg::CNT_BITS'(1));
            time_tally = saturating_sum(time_tally, dmc_pkg::CNT_BITS'(miss_price));
         end else begin
            time_tally = saturating_sum(time_tally, dmc_pkg::CNT_BITS'(hit_price));
         end
         access_tally = saturating_sum(access_tally, dmc_pkg::CNT_BITS'(1));
         res.read_data    = cached_bytes[set_idx * dmc_pkg::LINE_BYTES + offset];
         res.hit          = is_hit;
         res.access_count = access_tally;
         res.miss_count   = miss_tally;
         res.time_total   = time_tally;
         expected_reads.push_back(res);
      end
   endtask

   // Driver: feeds pending items and updates the prediction on every transfer.
   cache_req_type in_flight;
   int            send_gap = 0;
   int            send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         for (int i = 0; i < dmc_pkg::RAM_BYTES; i++) begin
            ram_image[i] = '0;
         end
         for (int i = 0; i < dmc_pkg::CACHE_BYTES; i++) begin
            cached_bytes[i] = 8'h23;
         end
         for (int i = 0; i < dmc_pkg::NUM_LINES; i++) begin
            cached_tag[i] = '0;
            line_live[i]  = 1'b0;
         end
         access_tally = '0;
         miss_tally   = '0;
         time_tally   = '0;
         hit_price    = dmc_pkg::HIT_COST_RESET;
         miss_price   = dmc_pkg::MISS_COST_RESET;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               dmc_pkg::REG_HIT_COST: begin
                  hit_price = csr_if.data;
               end
               dmc_pkg::REG_MISS_COST: begin
                  miss_price = csr_if.data;
               end
               default: begin
               end
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            predict_access(in_flight);
            accepted_total++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               in_flight = pending_reqs.pop_front();
               req_if.op        <= in_flight.op;
               req_if.address   <= in_flight.address;
               req_if.load_data <= in_flight.load_data;
               req_if.valid     <= 1'b1;
               draw_pause(send_calm, send_gap);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string field,
                                  input logic [dmc_pkg::CNT_BITS-1:0] got,
                                  input logic [dmc_pkg::CNT_BITS-1:0] want);
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
      error_count++;
   endtask

   // Monitor: takes results with random back-pressure and checks them in order.
   int              hold_left = 0;
   int              hold_calm = 0;
   read_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_reads.size() == 0) begin
               report_mismatch("unexpected result, read_data",
                               dmc_pkg::CNT_BITS'(rsp_if.read_data), '0);
            end else begin
               want = expected_reads.pop_front();
               if (rsp_if.read_data !== want.read_data)
                  report_mismatch("read_data", dmc_pkg::CNT_BITS'(rsp_if.read_data),
                                  dmc_pkg::CNT_BITS'(want.read_data));
               if (rsp_if.hit !== want.hit)
                  report_mismatch("hit", dmc_pkg::CNT_BITS'(rsp_if.hit),
                                  dmc_pkg::CNT_BITS'(want.hit));
               if (rsp_if.access_count !== want.access_count)
                  report_mismatch("access_count", rsp_if.access_count, want.access_count);
               if (rsp_if.miss_count !== want.miss_count)
                  report_mismatch("miss_count", rsp_if.miss_count, want.miss_count);
               if (rsp_if.time_total !== want.time_total)
                  report_mismatch("time_total", rsp_if.time_total, want.time_total);
            end
            draw_pause(hold_calm, hold_left);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_if.ready <= (hold_left == 0);
      end
   end

   // Watchdog on cycles without any transfer.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_preload(input logic [dmc_pkg::ADDR_BITS-1:0] addr,
                                input logic [dmc_pkg::DATA_BITS-1:0] value);
      cache_req_type item;
      item.op        = dmc_pkg::OP_PRELOAD;
      item.address   = addr;
      item.load_data = value;
      pending_reqs.push_back(item);
      ram_loaded[addr] = 1'b1;
      queued_total++;
   endtask

   // A refill copies the whole block, so every byte of it is loaded before the read.
   task automatic queue_read(input logic [dmc_pkg::ADDR_BITS-1:0] addr);
      cache_req_type                 item;
      logic [dmc_pkg::ADDR_BITS-1:0] base;
      int                            i;
      base = {addr[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS], dmc_pkg::OFFSET_BITS'(0)};
      for (i = 0; i < dmc_pkg::LINE_BYTES; i++) begin
         if (!ram_loaded[base + i])
            queue_preload(base + dmc_pkg::ADDR_BITS'(i), dmc_pkg::DATA_BITS'($urandom));
      end
      item.op        = dmc_pkg::OP_READ;
      item.address   = addr;
      item.load_data = dmc_pkg::DATA_BITS'($urandom);
      pending_reqs.push_back(item);
      queued_total++;
   endtask

   task automatic pick_hot_tags();
      for (int i = 0; i < dmc_pkg::NUM_LINES; i++) begin
         hot_tags[i][0] = dmc_pkg::TAG_BITS'($urandom);
         hot_tags[i][1] = dmc_pkg::TAG_BITS'($urandom);
      end
   endtask

   function automatic logic [dmc_pkg::ADDR_BITS-1:0] hot_address();
      logic [dmc_pkg::INDEX_BITS-1:0] set_idx;
      set_idx = dmc_pkg::INDEX_BITS'($urandom);
      return {hot_tags[set_idx][$urandom_range(0, 1)], set_idx,
              dmc_pkg::OFFSET_BITS'($urandom)};
   endfunction

   task automatic queue_directed();
      int i;
      for (i = 0; i < dmc_pkg::LINE_BYTES; i++) begin
         queue_preload(dmc_pkg::ADDR_BITS'(i), dmc_pkg::DATA_BITS'(i * 17));
         queue_preload(dmc_pkg::ADDR_BITS'(dmc_pkg::RAM_BYTES - dmc_pkg::LINE_BYTES + i),
                       dmc_pkg::DATA_BITS'(8'hFF ^ (i * 17)));
      end
      queue_read(dmc_pkg::ADDR_BITS'(0));
      queue_read(dmc_pkg::ADDR_BITS'(dmc_pkg::LINE_BYTES - 1));
      queue_read(dmc_pkg::ADDR_BITS'(dmc_pkg::RAM_BYTES - 1));
      queue_read(dmc_pkg::ADDR_BITS'(dmc_pkg::RAM_BYTES - dmc_pkg::LINE_BYTES));
      // A preload to a cached block must not change what the line returns.
      queue_preload(dmc_pkg::ADDR_BITS'(3), 8'hA5);
      queue_read(dmc_pkg::ADDR_BITS'(3));
      // Same line, other tag: evicts block zero, so the next read refills it.
      queue_read({1'b1, {(dmc_pkg::ADDR_BITS - 1){1'b0}}});
      queue_read(dmc_pkg::ADDR_BITS'(3));
   endtask

   task automatic queue_random_traffic(input int count);
      int target;
      int pick;
      target = queued_total + count;
      while (queued_total < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 72)
            queue_read(hot_address());
         else if (pick < 78)
            queue_read(dmc_pkg::ADDR_BITS'($urandom));
         else if (pick < 92)
            queue_preload(hot_address(), dmc_pkg::DATA_BITS'($urandom));
         else
            queue_preload(dmc_pkg::ADDR_BITS'($urandom), dmc_pkg::DATA_BITS'($urandom));
      end
   endtask

   task automatic await_idle();
      while (accepted_total != queued_total || expected_reads.size() != 0)
         @(posedge clock);
      // All preloads and reads are complete here; the bench still settles before the next phase.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back register writes keep valid high between transfers.
   task automatic program_costs(input logic [dmc_pkg::COST_BITS-1:0] hit_value,
                                input logic [dmc_pkg::COST_BITS-1:0] miss_value);
      logic [dmc_pkg::CSR_INDEX_BITS-1:0] idx[3];
      logic [dmc_pkg::CSR_DATA_BITS-1:0]  val[3];
      idx[0] = dmc_pkg::REG_HIT_COST;
      val[0] = hit_value;
      idx[1] = dmc_pkg::REG_MISS_COST;
      val[1] = miss_value;
      idx[2] = dmc_pkg::CSR_INDEX_BITS'($urandom_range(REG_FIRST_UNUSED,
                                                       (1 << dmc_pkg::CSR_INDEX_BITS) - 1));
      val[2] = dmc_pkg::CSR_DATA_BITS'($urandom);
      for (int k = 0; k < 3; k++) begin
         csr_if.index <= idx[k];
         csr_if.data  <= val[k];
         csr_if.valid <= 1'b1;
         do @(posedge clock); while (!csr_if.ready);
      end
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.op        = dmc_pkg::OP_PRELOAD;
      req_if.address   = '0;
      req_if.load_data = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      for (int i = 0; i < dmc_pkg::RAM_BYTES; i++) begin
         ram_loaded[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_directed();
      await_idle();

      program_costs(8'd0, 8'd255);
      pick_hot_tags();
      queue_random_traffic(PHASE_ITEMS);
      await_idle();

      program_costs(8'd255, 8'd0);
      pick_hot_tags();
      queue_random_traffic(PHASE_ITEMS);
      await_idle();

      program_costs(8'd1, 8'd1);
      pick_hot_tags();
      queue_random_traffic(PHASE_ITEMS);
      await_idle();

      program_costs(dmc_pkg::COST_BITS'($urandom_range(1, 255)),
                    dmc_pkg::COST_BITS'($urandom_range(1, 255)));
      pick_hot_tags();
      queue_random_traffic(PHASE_ITEMS);
      await_idle();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
sv/dmc_pkg.sv
sv/dmc_ifs.sv
sv/dmc_ram.sv
sv/dmc_controller.sv
sv/dmc_datapath.sv
sv/direct_mapped_cache_read_core.sv
bench/testbench.sv
